// ===== rtl/core/demand_paging_translator_macros.svh =====
// Assertion macros for the translator RTL, included by dpt_back.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef DEMAND_PAGING_TRANSLATOR_MACROS_SVH
`define DEMAND_PAGING_TRANSLATOR_MACROS_SVH

// Plain property, checked out of reset
`define DPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication, checked out of reset
`define DPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dpt_pkg.sv =====
// Shared types and fixed constants of the demand paging translator.
// No dependencies.
package dpt_pkg;

  localparam int unsigned VA_W       = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PHYS_W     = 16;
  localparam int unsigned PAGE_OUT_W = 8;

  // Input word kinds
  typedef enum logic {
    OP_XLATE = 1'b0,
    OP_FILL  = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_FAULT  = 2'd1,
    ST_DONE   = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  // Classified command from front to back
  typedef struct packed {
    op_e                      op;
    logic [VA_W-1:0]          va;
    logic signed [BYTE_W-1:0] fb;
  } cmd_t;

  // Result word
  typedef struct packed {
    status_e                  status;
    logic [VA_W-1:0]          va;
    logic [PHYS_W-1:0]        pa;
    logic signed [BYTE_W-1:0] data;
    logic [PAGE_OUT_W-1:0]    page;
  } res_t;

endpackage

// ===== rtl/core/dpt_front.sv =====
// Front end: accepts input words, classifies them, queues them for the back end.
// Depends on dpt_pkg.
module dpt_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic                                func_i,
  input  logic [dpt_pkg::VA_W-1:0]            virt_address_i,
  input  logic signed [dpt_pkg::BYTE_W-1:0]   fill_byte_i,
  input  logic                                hold_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output dpt_pkg::cmd_t                       cmd_o
);
  import dpt_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;
  localparam int unsigned CNT_W = 2;

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push_ok, pop_ok;
  cmd_t             in_cmd;

  // Classify the incoming word
  always_comb begin
    in_cmd.op = func_i ? OP_FILL : OP_XLATE;
    in_cmd.va = virt_address_i;
    in_cmd.fb = fill_byte_i;
  end

  // Handshake; hold keeps the queue closed while the back end is clearing
  assign full_o      = (cnt_q == CNT_W'(DEPTH)) || hold_i;
  assign push_ok     = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop_ok      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ===== rtl/core/dpt_back.sv =====
// Back end: page table, frame memory, fault/fill sequencer and result queue.
// Depends on dpt_pkg and demand_paging_translator_macros.svh.
module dpt_back #(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned NUM_FRAMES  = 256,
  parameter int unsigned PAGE_BYTES  = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  dpt_pkg::cmd_t  cmd_i,
  output logic           clearing_o,
  output logic           empty_o,
  input  logic           pop_i,
  output dpt_pkg::res_t  res_o
);
  import dpt_pkg::*;
  `include "demand_paging_translator_macros.svh"

  localparam int unsigned PAGE_W    = VA_W - OFFSET_BITS;
  localparam int unsigned NUM_PAGES = 1 << PAGE_W;
  localparam int unsigned FRAME_W   = $clog2(NUM_FRAMES);
  localparam int unsigned NF_W      = $clog2(NUM_FRAMES + 1);
  localparam int unsigned MEM_BYTES = NUM_FRAMES * PAGE_BYTES;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned PA_W      = $clog2(MEM_BYTES + (1 << OFFSET_BITS));
  localparam int unsigned FIDX_W    = $clog2(PAGE_BYTES);
  localparam int unsigned ODEPTH    = 2;
  localparam int unsigned OPTR_W    = 1;
  localparam int unsigned OCNT_W    = 2;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_WRAP   = 5'b01000,
    S_READ   = 5'b10000
  } state_e;

  // Sequencer state
  state_e              state_q, state_d;
  logic [PAGE_W-1:0]   clr_idx_q, clr_idx_d;
  logic [NF_W-1:0]     next_frame_q, next_frame_d;
  logic                fill_pending_q, fill_pending_d;
  logic [FIDX_W-1:0]   fill_index_q, fill_index_d;
  logic [VA_W-1:0]     pending_q, pending_d;
  logic [VA_W-1:0]     cur_va_q, cur_va_d;
  status_e             cur_st_q, cur_st_d;
  logic [PA_W-1:0]     pa_q, pa_d;
  logic [PA_W-1:0]     idx_q, idx_d;

  // Memories and registered read data
  logic                pt_valid_mem [NUM_PAGES];
  logic [FRAME_W-1:0]  pt_frame_mem [NUM_PAGES];
  logic [BYTE_W-1:0]   frame_mem    [MEM_BYTES];
  logic                ptv_rd_q;
  logic [FRAME_W-1:0]  ptf_rd_q;
  logic signed [BYTE_W-1:0] fm_rd_q;

  // Memory port controls
  logic                ptv_we, ptv_wdata;
  logic [PAGE_W-1:0]   ptv_waddr;
  logic                ptf_we;
  logic [PAGE_W-1:0]   pt_raddr;
  logic                fm_we;
  logic [MEM_AW-1:0]   fm_waddr;
  logic [MEM_AW-1:0]   fm_raddr;

  // Address arithmetic
  logic [FRAME_W-1:0]  base_frame;
  logic [OFFSET_BITS-1:0] base_ofs;
  logic [PA_W-1:0]     base_prod;
  logic [PA_W-1:0]     pa_calc;
  logic                frames_left;
  logic                fill_last;

  // Result queue
  res_t                oq_q [ODEPTH];
  logic [OPTR_W-1:0]   owr_q, ord_q;
  logic [OCNT_W-1:0]   ocnt_q, ocnt_d;
  logic                out_full, res_push, res_pop, cmd_take;
  res_t                res_d;

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_full    = (ocnt_q == OCNT_W'(ODEPTH));
  assign cmd_ready_o = (state_q == S_IDLE) && !out_full;
  assign cmd_take    = cmd_valid_i && cmd_ready_o;

  // Frame base times page size plus offset
  always_comb begin
    if ((state_q == S_LOOKUP) && ptv_rd_q) begin
      base_frame = ptf_rd_q;
    end else begin
      base_frame = FRAME_W'(next_frame_q);
    end
    base_ofs  = (state_q == S_LOOKUP) ? cur_va_q[OFFSET_BITS-1:0]
                                      : pending_q[OFFSET_BITS-1:0];
    base_prod = PA_W'(base_frame) * PA_W'(PAGE_BYTES);
    pa_calc   = base_prod + PA_W'(base_ofs);
  end

  assign frames_left = (next_frame_q < NF_W'(NUM_FRAMES));
  assign fill_last   = (fill_index_q == FIDX_W'(PAGE_BYTES - 1));
  assign pt_raddr    = cmd_i.va[VA_W-1:OFFSET_BITS];
  assign fm_waddr    = MEM_AW'(base_prod) + MEM_AW'(fill_index_q);
  assign fm_raddr    = MEM_AW'(idx_q);

  // Sequencer
  always_comb begin
    state_d        = state_q;
    clr_idx_d      = clr_idx_q;
    next_frame_d   = next_frame_q;
    fill_pending_d = fill_pending_q;
    fill_index_d   = fill_index_q;
    pending_d      = pending_q;
    cur_va_d       = cur_va_q;
    cur_st_d       = cur_st_q;
    pa_d           = pa_q;
    idx_d          = idx_q;
    ptv_we         = 1'b0;
    ptv_wdata      = 1'b0;
    ptv_waddr      = pending_q[VA_W-1:OFFSET_BITS];
    ptf_we         = 1'b0;
    fm_we          = 1'b0;
    res_push       = 1'b0;
    res_d          = '0;
    res_d.status   = ST_REJECT;
    res_d.va       = cmd_i.va;

    unique case (state_q)
      S_CLEAR: begin
        ptv_we    = 1'b1;
        ptv_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + PAGE_W'(1);
        if (clr_idx_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_take) begin
          if (cmd_i.op == OP_XLATE) begin
            if (fill_pending_q) begin
              res_push = 1'b1;
            end else begin
              cur_va_d = cmd_i.va;
              state_d  = S_LOOKUP;
            end
          end else if (!fill_pending_q) begin
            res_push = 1'b1;
          end else begin
            fm_we = 1'b1;
            if (fill_last) begin
              // Page complete: map it and read back the pending byte
              ptv_we         = 1'b1;
              ptv_wdata      = 1'b1;
              ptf_we         = 1'b1;
              next_frame_d   = next_frame_q + NF_W'(1);
              fill_pending_d = 1'b0;
              fill_index_d   = '0;
              pa_d           = pa_calc;
              idx_d          = pa_calc;
              cur_va_d       = pending_q;
              cur_st_d       = ST_DONE;
              state_d        = S_WRAP;
            end else begin
              fill_index_d = fill_index_q + FIDX_W'(1);
            end
          end
        end
      end
      S_LOOKUP: begin
        if (ptv_rd_q) begin
          pa_d     = pa_calc;
          idx_d    = pa_calc;
          cur_st_d = ST_HIT;
          state_d  = S_WRAP;
        end else if (!frames_left) begin
          res_push = 1'b1;
          res_d.va = cur_va_q;
          state_d  = S_IDLE;
        end else begin
          fill_pending_d = 1'b1;
          fill_index_d   = '0;
          pending_d      = cur_va_q;
          res_push       = 1'b1;
          res_d.status   = ST_FAULT;
          res_d.va       = cur_va_q;
          res_d.pa       = PHYS_W'(pa_calc);
          res_d.page     = PAGE_OUT_W'(cur_va_q[VA_W-1:OFFSET_BITS]);
          state_d        = S_IDLE;
        end
      end
      S_WRAP: begin
        // Fold the address into frame memory, one subtract per cycle
        if (idx_q >= PA_W'(MEM_BYTES)) begin
          idx_d = idx_q - PA_W'(MEM_BYTES);
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        res_push     = 1'b1;
        res_d.status = cur_st_q;
        res_d.va     = cur_va_q;
        res_d.pa     = PHYS_W'(pa_q);
        res_d.data   = fm_rd_q;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_idx_q      <= '0;
      next_frame_q   <= '0;
      fill_pending_q <= 1'b0;
      fill_index_q   <= '0;
      pending_q      <= '0;
      cur_st_q       <= ST_HIT;
    end else begin
      state_q        <= state_d;
      clr_idx_q      <= clr_idx_d;
      next_frame_q   <= next_frame_d;
      fill_pending_q <= fill_pending_d;
      fill_index_q   <= fill_index_d;
      pending_q      <= pending_d;
      cur_st_q       <= cur_st_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_va_q <= cur_va_d;
    pa_q     <= pa_d;
    idx_q    <= idx_d;
  end

  // Page table valid bits
  always_ff @(posedge clk_i) begin
    if (ptv_we) begin
      pt_valid_mem[ptv_waddr] <= ptv_wdata;
    end
    ptv_rd_q <= pt_valid_mem[pt_raddr];
  end

  // Page table frame numbers
  always_ff @(posedge clk_i) begin
    if (ptf_we) begin
      pt_frame_mem[ptv_waddr] <= FRAME_W'(next_frame_q);
    end
    ptf_rd_q <= pt_frame_mem[pt_raddr];
  end

  // Frame memory
  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= cmd_i.fb;
    end
    fm_rd_q <= frame_mem[fm_raddr];
  end

  // Result queue
  assign empty_o = (ocnt_q == '0);
  assign res_pop = pop_i && !empty_o;
  assign res_o   = oq_q[ord_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (res_push && !res_pop) begin
      ocnt_d = ocnt_q + OCNT_W'(1);
    end else if (res_pop && !res_push) begin
      ocnt_d = ocnt_q - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (res_push) begin
        owr_q <= owr_q + OPTR_W'(1);
      end
      if (res_pop) begin
        ord_q <= ord_q + OPTR_W'(1);
      end
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[owr_q] <= res_d;
    end
  end

  // Checks
  `DPT_ASSERT_IMPL(a_fill_idx_idle, !fill_pending_q, fill_index_q == '0, "fill index moved")
  `DPT_ASSERT(a_frame_bound, next_frame_q <= NF_W'(NUM_FRAMES), "frame counter overran")
  `DPT_ASSERT_IMPL(a_push_room, res_push, !out_full, "result queue overflow")
  `DPT_ASSERT_IMPL(a_clear_closed, state_q == S_CLEAR, !cmd_ready_o, "command taken while clearing")

endmodule

// ===== rtl/core/demand_paging_translator.sv =====
// Fill words are taken one per cycle while the result queue has room; the last fill of
// a page holds the back end through wrap and read, a hit through lookup, wrap and read,
// a fault through lookup. Each extra frame-memory fold (offset wider than a page) adds
// a pass through S_WRAP to a read. After reset the valid bits of all 2**(16-OFFSET_BITS)
// page table entries are cleared, one page per cycle; full stays high during that pass.
module demand_paging_translator #(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned NUM_FRAMES  = 256,
  parameter int unsigned PAGE_BYTES  = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                func_i,
  input  logic [dpt_pkg::VA_W-1:0]            virt_address_i,
  input  logic signed [dpt_pkg::BYTE_W-1:0]   fill_byte_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [1:0]                          status_o,
  output logic [dpt_pkg::VA_W-1:0]            virt_echo_o,
  output logic [dpt_pkg::PHYS_W-1:0]          phys_address_o,
  output logic signed [dpt_pkg::BYTE_W-1:0]   data_value_o,
  output logic [dpt_pkg::PAGE_OUT_W-1:0]      fault_page_o
);
  import dpt_pkg::*;

  logic cmd_valid, cmd_ready, clearing;
  cmd_t cmd;
  res_t res;

  // Front: accept and classify
  dpt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .func_i         (func_i),
    .virt_address_i (virt_address_i),
    .fill_byte_i    (fill_byte_i),
    .hold_i         (clearing),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  // Back: translate, fault, fill
  dpt_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .NUM_FRAMES  (NUM_FRAMES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .clearing_o  (clearing),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  // Result word onto ports
  assign status_o       = res.status;
  assign virt_echo_o    = res.va;
  assign phys_address_o = res.pa;
  assign data_value_o   = res.data;
  assign fault_page_o   = res.page;

endmodule

// ===== test/tb_demand_paging_translator.sv =====
// Self-checking testbench for demand_paging_translator: queue-style driver and monitor,
// with an in-bench page table / frame memory predictor checked against every result word.
// Depends on dpt_pkg and the translator RTL.
module tb_demand_paging_translator;
  import dpt_pkg::*;

  localparam int unsigned OFS_BITS   = 8;
  localparam int unsigned FRAMES     = 256;
  localparam int unsigned PG_BYTES   = 256;
  localparam int unsigned NPAGES     = 1 << (16 - OFS_BITS);
  localparam int unsigned MEM_BYTES  = FRAMES * PG_BYTES;
  localparam int unsigned OFS_MASK   = (1 << OFS_BITS) - 1;
  localparam int unsigned RAND_ITEMS = 1850;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               push           = 1'b0;
  logic               full;
  logic               func_i         = 1'b0;
  logic [15:0]        virt_address_i = '0;
  logic signed [7:0]  fill_byte_i    = '0;
  logic               empty;
  logic               pop            = 1'b0;
  logic [1:0]         status_o;
  logic [15:0]        virt_echo_o;
  logic [15:0]        phys_address_o;
  logic signed [7:0]  data_value_o;
  logic [7:0]         fault_page_o;

  demand_paging_translator #(
    .OFFSET_BITS(OFS_BITS),
    .NUM_FRAMES (FRAMES),
    .PAGE_BYTES (PG_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .virt_address_i(virt_address_i),
    .fill_byte_i   (fill_byte_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .virt_echo_o   (virt_echo_o),
    .phys_address_o(phys_address_o),
    .data_value_o  (data_value_o),
    .fault_page_o  (fault_page_o)
  );

  always #10 clk_i = ~clk_i;

  // Predicted translator state
  bit               tbl_valid [NPAGES];
  int unsigned      tbl_frame [NPAGES];
  logic signed [7:0] frame_mem [MEM_BYTES];
  int unsigned      free_frame = 0;
  bit               filling    = 1'b0;
  int unsigned      fill_cnt   = 0;
  logic [15:0]      fault_va   = '0;

  // Words waiting to be pushed, and translations waiting to be popped
  cmd_t        pending_words[$];
  res_t        awaited_xlate[$];
  int unsigned n_words    = 0;
  int unsigned n_accepted = 0;
  int          err_cnt    = 0;

  // Stimulus generator bookkeeping
  bit          gen_mapped [NPAGES];
  logic [7:0]  gen_pages[$];

  function automatic int unsigned phys_of(input int unsigned frame, input logic [15:0] va);
    return frame * PG_BYTES + (va & OFS_MASK);
  endfunction

  // Compute the result word (if any) one input word causes, updating the predicted state
  task automatic translate_word(input cmd_t w, output bit has_res, output res_t r);
    int unsigned pg;
    int unsigned pa;
    has_res = 1'b1;
    r       = '0;
    r.va    = w.va;
    pg      = (w.va >> OFS_BITS) % NPAGES;
    if (w.op == OP_XLATE) begin
      if (filling) begin
        r.status = ST_REJECT;
      end else if (tbl_valid[pg]) begin
        pa       = phys_of(tbl_frame[pg], w.va);
        r.status = ST_HIT;
        r.pa     = pa[15:0];
        r.data   = frame_mem[pa % MEM_BYTES];
      end else if (free_frame >= FRAMES) begin
        r.status = ST_REJECT;
      end else begin
        filling  = 1'b1;
        fill_cnt = 0;
        fault_va = w.va;
        pa       = phys_of(free_frame, w.va);
        r.status = ST_FAULT;
        r.pa     = pa[15:0];
        r.page   = pg[7:0];
      end
    end else if (!filling) begin
      r.status = ST_REJECT;
    end else begin
      frame_mem[(free_frame * PG_BYTES + fill_cnt) % MEM_BYTES] = w.fb;
      fill_cnt++;
      if (fill_cnt < PG_BYTES) begin
        has_res = 1'b0;
      end else begin
        // last fill byte: map the page and report the finished translation
        pg            = (fault_va >> OFS_BITS) % NPAGES;
        pa            = phys_of(free_frame, fault_va);
        tbl_valid[pg] = 1'b1;
        tbl_frame[pg] = free_frame;
        free_frame++;
        filling       = 1'b0;
        fill_cnt      = 0;
        r.status      = ST_DONE;
        r.va          = fault_va;
        r.pa          = pa[15:0];
        r.data        = frame_mem[pa % MEM_BYTES];
      end
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(4, 40);
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic add_word(input op_e op, input logic [15:0] va, input logic signed [7:0] fb);
    cmd_t w;
    w.op = op;
    w.va = va;
    w.fb = fb;
    pending_words.push_back(w);
    n_words++;
  endtask

  // One page worth of fill words; noisy runs slip in translate words that get rejected
  task automatic add_fills(input bit patterned, input bit noisy);
    int i;
    for (i = 0; i < PG_BYTES; i++) begin
      if (noisy && $urandom_range(0, 39) == 0)
        add_word(OP_XLATE, 16'($urandom), 8'($urandom));
      add_word(OP_FILL, 16'($urandom), patterned ? i[7:0] : 8'($urandom));
    end
  endtask

  // Driver: present the next word once the previous one is taken
  int unsigned push_idle = 0;
  int unsigned push_calm = 0;
  cmd_t        cur_word;
  bit          drv_has;
  res_t        drv_res;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        translate_word(cur_word, drv_has, drv_res);
        if (drv_has) awaited_xlate.push_back(drv_res);
        n_accepted++;
      end
      if (push_idle != 0) begin
        push_idle--;
        push <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word       = pending_words.pop_front();
        func_i         <= cur_word.op;
        virt_address_i <= cur_word.va;
        fill_byte_i    <= cur_word.fb;
        push           <= 1'b1;
        if (push_calm != 0) begin
          push_calm--;
          push_idle = 0;
        end else begin
          push_idle = draw_gap();
          if ($urandom_range(0, 149) == 0) push_calm = $urandom_range(40, 300);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: take result words and compare against the oldest prediction
  int unsigned pop_hold = 0;
  int unsigned pop_calm = 0;
  res_t        mon_exp;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_xlate.size() == 0) begin
          $error("unexpected result word: status %0d virt_echo %h", status_o, virt_echo_o);
          err_cnt++;
        end else begin
          mon_exp = awaited_xlate.pop_front();
          check_field("status", mon_exp.status, status_o);
          check_field("virt_echo", mon_exp.va, virt_echo_o);
          check_field("phys_address", mon_exp.pa, phys_address_o);
          check_field("data_value", mon_exp.data, data_value_o);
          check_field("fault_page", mon_exp.page, fault_page_o);
        end
        if (pop_calm != 0) begin
          pop_calm--;
          pop_hold = 0;
        end else begin
          pop_hold = draw_gap();
          if ($urandom_range(0, 29) == 0) pop_calm = $urandom_range(10, 60);
        end
      end
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned limit;
    int unsigned r;
    logic [7:0]  pg;
    logic [15:0] va;

    foreach (frame_mem[k]) frame_mem[k] = '0;

    // Directed: stray fill, fault with reject while pending, hits at page edges
    add_word(OP_FILL, 16'hFFFF, 8'h80);
    add_word(OP_XLATE, 16'h0000, 8'h7F);
    add_word(OP_XLATE, 16'hFFFF, 8'h00);
    add_fills(1'b1, 1'b0);
    add_word(OP_XLATE, 16'h0000, 8'hFF);
    add_word(OP_XLATE, 16'h00FF, 8'h00);
    add_word(OP_XLATE, 16'h0080, 8'h00);
    add_word(OP_XLATE, 16'hFFFF, 8'h55);
    add_fills(1'b1, 1'b0);
    add_word(OP_XLATE, 16'hFF00, 8'h00);
    add_word(OP_XLATE, 16'hFFFF, 8'h00);
    add_word(OP_XLATE, 16'hFF7F, 8'h00);
    add_word(OP_FILL, 16'h0000, 8'h7F);
    add_word(OP_XLATE, 16'h0001, 8'h00);
    gen_mapped[8'h00] = 1'b1;
    gen_mapped[8'hFF] = 1'b1;
    gen_pages.push_back(8'h00);
    gen_pages.push_back(8'hFF);

    // Random: mostly hits on mapped pages, occasional fault runs, some stray fills
    limit = RAND_ITEMS;
    while (n_words < limit) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        do pg = 8'($urandom); while (gen_mapped[pg]);
        add_word(OP_XLATE, {pg, 8'($urandom)}, 8'($urandom));
        add_fills(1'b0, 1'b1);
        gen_mapped[pg] = 1'b1;
        gen_pages.push_back(pg);
      end else if (r < 8) begin
        add_word(OP_FILL, 16'($urandom), 8'($urandom));
      end else if (r < 13) begin
        va = 16'($urandom);
        add_word(OP_XLATE, va, 8'($urandom));
        if (!gen_mapped[va[15:8]]) begin
          add_fills(1'b0, 1'b1);
          gen_mapped[va[15:8]] = 1'b1;
          gen_pages.push_back(va[15:8]);
        end
      end else begin
        pg = gen_pages[$urandom_range(0, gen_pages.size() - 1)];
        add_word(OP_XLATE, {pg, 8'($urandom)}, 8'($urandom));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_words) @(posedge clk_i);
    while (awaited_xlate.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("demand_paging_translator verification clean");
    end else begin
      $display("demand_paging_translator verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("demand_paging_translator verification failed");
    $finish;
  end

endmodule
